### rtl/fsts_pkg.sv
package fsts_pkg;

    localparam int TIME_POOL_BITS_DEF = 48;

    localparam int CMD_W       = 2;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 32;
    localparam int STEP_W      = 32;
    localparam int MAXS_W      = 8;
    localparam int CREDIT_W    = 32;
    localparam int ALPHA_W     = 16;
    localparam int OVF_CNT_W   = 32;
    localparam int TOTAL_W     = 64;

    typedef logic [CMD_W-1:0]     t_cmd;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cmd CMD_TICK   = 2'd0;
    localparam t_cmd CMD_CREDIT = 2'd1;
    localparam t_cmd CMD_PAUSE  = 2'd2;
    localparam t_cmd CMD_RESUME = 2'd3;

    localparam t_cfg_idx CFG_STEP_UNITS = 4'd0;
    localparam t_cfg_idx CFG_MAX_STEPS  = 4'd1;

    localparam logic [STEP_W-1:0] STEP_UNITS_RESET = 32'd16667;
    localparam logic [MAXS_W-1:0] MAX_STEPS_RESET  = 8'd5;

endpackage

### rtl/fsts_if.sv
interface fsts_in_if;
    logic                                   valid;
    logic                                   ready;
    logic [fsts_pkg::CMD_W-1:0]             cmd;
    logic signed [31:0]                     frame_time;
    logic signed [31:0]                     credit_amount;

    modport source (output valid, output cmd, output frame_time, output credit_amount,
                    input ready);
    modport sink   (input valid, input cmd, input frame_time, input credit_amount,
                    output ready);
endinterface

interface fsts_out_if;
    logic                                   valid;
    logic                                   ready;
    logic [fsts_pkg::MAXS_W-1:0]            steps_now;
    logic                                   overflowed;
    logic [fsts_pkg::ALPHA_W-1:0]           alpha_q16;
    logic [fsts_pkg::OVF_CNT_W-1:0]         overflow_total;
    logic [fsts_pkg::TOTAL_W-1:0]           steps_total;

    modport source (output valid, output steps_now, output overflowed, output alpha_q16,
                    output overflow_total, output steps_total, input ready);
    modport sink   (input valid, input steps_now, input overflowed, input alpha_q16,
                    input overflow_total, input steps_total, output ready);
endinterface

interface fsts_cfg_if;
    logic                                   valid;
    logic                                   ready;
    logic [fsts_pkg::CFG_IDX_W-1:0]         index;
    logic [fsts_pkg::CFG_DATA_W-1:0]        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/fixed_step_tick_scheduler.sv
// tick item: result after two capped divisions and, unless paused or alpha saturates,
// a fraction division, all on one subtractor
// credit, pause and resume items: no result
// input not ready while a tick is worked; next item taken once its result is loaded
// reset: synchronous, active low; clears pools, totals and pause, config to defaults
module fixed_step_tick_scheduler #(
    parameter int TIME_POOL_BITS = fsts_pkg::TIME_POOL_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fsts_cfg_if.sink      i_cfg,
    fsts_in_if.sink       i_in,
    fsts_out_if.source    o_out
);

    localparam int PW = TIME_POOL_BITS;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DIV1  = 4'd1;
    localparam logic [3:0] ST_POP   = 4'd2;
    localparam logic [3:0] ST_SUB1  = 4'd3;
    localparam logic [3:0] ST_DIV2  = 4'd4;
    localparam logic [3:0] ST_DROP  = 4'd5;
    localparam logic [3:0] ST_SUB2  = 4'd6;
    localparam logic [3:0] ST_ACHK  = 4'd7;
    localparam logic [3:0] ST_ALPHA = 4'd8;
    localparam logic [3:0] ST_DONE  = 4'd9;

    logic [3:0]                        r_state, n_state;
    logic [fsts_pkg::STEP_W-1:0]       r_step, n_step;
    logic [fsts_pkg::MAXS_W-1:0]       r_max, n_max;
    logic [PW-1:0]                     r_pool, n_pool;
    logic [fsts_pkg::CREDIT_W-1:0]     r_credit, n_credit;
    logic                              r_paused, n_paused;
    logic [fsts_pkg::OVF_CNT_W-1:0]    r_ovf_cnt, n_ovf_cnt;
    logic [fsts_pkg::TOTAL_W-1:0]      r_popped, n_popped;
    logic                              r_out_valid, n_out_valid;

    logic [PW-1:0]                     r_rem, n_rem;
    logic [15:0]                       r_q, n_q;
    logic [3:0]                        r_k, n_k;
    logic [39:0]                       r_prod, n_prod;
    logic [7:0]                        r_pop, n_pop;
    logic                              r_ovf, n_ovf;

    logic [fsts_pkg::MAXS_W-1:0]       r_o_steps;
    logic                              r_o_ovf;
    logic [fsts_pkg::ALPHA_W-1:0]      r_o_alpha;
    logic [fsts_pkg::OVF_CNT_W-1:0]    r_o_ovf_total;
    logic [fsts_pkg::TOTAL_W-1:0]      r_o_total;

    logic [PW-1:0]                     sub_a, sub_b, sub_diff;
    logic                              sub_ge;
    logic [fsts_pkg::STEP_W-1:0]       step_eff;
    logic [7:0]                        capped;
    logic [32:0]                       pop_total;
    logic [32:0]                       credit_sum;
    logic [PW:0]                       pool_sum;
    logic [31:0]                       ft_eff;
    logic [31:0]                       ca_u;
    logic [7:0]                        pop;
    logic [7:0]                        credit_take;
    logic                              in_fire, out_load;

    fsts_sub #(.W(PW)) u_sub (
        .i_a    (sub_a),
        .i_b    (sub_b),
        .o_diff (sub_diff),
        .o_ge   (sub_ge)
    );

    assign step_eff   = (r_step == '0) ? 32'd1 : r_step;
    assign in_fire    = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign out_load   = (r_state == ST_DONE) && (!r_out_valid || o_out.ready);

    // min(quotient, r_max); bit 8 set means the quotient already exceeds any cap
    assign capped = (r_q[8] || (r_q[7:0] > r_max)) ? r_max : r_q[7:0];

    assign ft_eff     = (r_paused || i_in.frame_time[31]) ? 32'd0 : i_in.frame_time;
    assign ca_u       = i_in.credit_amount;
    assign pool_sum   = {1'b0, r_pool} + (PW + 1)'(ft_eff);
    assign credit_sum = {1'b0, r_credit} + {1'b0, ca_u};

    assign pop_total   = 33'(capped) + 33'(r_credit);
    assign pop         = (pop_total > 33'(r_max)) ? r_max : pop_total[7:0];
    assign credit_take = (r_credit < 32'(pop)) ? r_credit[7:0] : pop;

    always_comb begin
        unique case (r_state)
            ST_DIV1, ST_DIV2: begin
                sub_a = r_rem;
                sub_b = PW'(step_eff) << r_k;
            end
            ST_SUB1, ST_SUB2: begin
                sub_a = r_pool;
                sub_b = PW'(r_prod);
            end
            ST_ACHK: begin
                sub_a = r_pool;
                sub_b = PW'(step_eff);
            end
            ST_ALPHA: begin
                sub_a = r_rem << 1;
                sub_b = PW'(step_eff);
            end
            default: begin
                sub_a = '0;
                sub_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_max       = r_max;
        n_pool      = r_pool;
        n_credit    = r_credit;
        n_paused    = r_paused;
        n_ovf_cnt   = r_ovf_cnt;
        n_popped    = r_popped;
        n_out_valid = r_out_valid && !o_out.ready;
        n_rem       = r_rem;
        n_q         = r_q;
        n_k         = r_k;
        n_prod      = r_prod;
        n_pop       = r_pop;
        n_ovf       = r_ovf;

        if (i_cfg.valid && i_cfg.ready) begin
            if (i_cfg.index == fsts_pkg::CFG_STEP_UNITS) begin
                n_step = i_cfg.data;
            end else if (i_cfg.index == fsts_pkg::CFG_MAX_STEPS) begin
                n_max = i_cfg.data[7:0];
            end
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    unique case (i_in.cmd)
                        fsts_pkg::CMD_TICK: begin
                            n_pool  = pool_sum[PW] ? '1 : pool_sum[PW-1:0];
                            n_rem   = pool_sum[PW] ? '1 : pool_sum[PW-1:0];
                            n_q     = '0;
                            n_k     = 4'd8;
                            n_state = ST_DIV1;
                        end
                        fsts_pkg::CMD_CREDIT: begin
                            if (ca_u != '0 && !ca_u[31]) begin
                                n_credit = credit_sum[32] ? '1 : credit_sum[31:0];
                            end
                        end
                        fsts_pkg::CMD_PAUSE:  n_paused = 1'b1;
                        fsts_pkg::CMD_RESUME: n_paused = 1'b0;
                        default: ;
                    endcase
                end
            end
            ST_DIV1, ST_DIV2: begin
                if (sub_ge) begin
                    n_rem = sub_diff;
                end
                n_q = {r_q[14:0], sub_ge};
                n_k = r_k - 4'd1;
                if (r_k == '0) begin
                    n_state = (r_state == ST_DIV1) ? ST_POP : ST_DROP;
                end
            end
            ST_POP: begin
                n_pop    = pop;
                n_credit = r_credit - 32'(credit_take);
                n_prod   = 40'(pop - credit_take) * 40'(step_eff);
                n_state  = ST_SUB1;
            end
            ST_SUB1: begin
                n_pool  = sub_diff;
                n_rem   = sub_diff;
                n_q     = '0;
                n_k     = 4'd8;
                n_state = ST_DIV2;
            end
            ST_DROP: begin
                n_prod  = 40'(capped) * 40'(step_eff);
                n_ovf   = (capped != '0);
                n_state = ST_SUB2;
            end
            ST_SUB2: begin
                n_pool  = sub_diff;
                n_state = ST_ACHK;
            end
            ST_ACHK: begin
                if (r_paused) begin
                    n_q     = '0;
                    n_state = ST_DONE;
                end else if (sub_ge) begin
                    n_q     = '1;
                    n_state = ST_DONE;
                end else begin
                    n_rem   = r_pool;
                    n_q     = '0;
                    n_k     = 4'd15;
                    n_state = ST_ALPHA;
                end
            end
            ST_ALPHA: begin
                n_rem = sub_ge ? sub_diff : (r_rem << 1);
                n_q   = {r_q[14:0], sub_ge};
                n_k   = r_k - 4'd1;
                if (r_k == '0) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    if (r_ovf && r_ovf_cnt != '1) begin
                        n_ovf_cnt = r_ovf_cnt + 32'd1;
                    end
                    n_popped    = r_popped + 64'(r_pop);
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= fsts_pkg::STEP_UNITS_RESET;
            r_max       <= fsts_pkg::MAX_STEPS_RESET;
            r_pool      <= '0;
            r_credit    <= '0;
            r_paused    <= 1'b0;
            r_ovf_cnt   <= '0;
            r_popped    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_max       <= n_max;
            r_pool      <= n_pool;
            r_credit    <= n_credit;
            r_paused    <= n_paused;
            r_ovf_cnt   <= n_ovf_cnt;
            r_popped    <= n_popped;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_q    <= n_q;
        r_k    <= n_k;
        r_prod <= n_prod;
        r_pop  <= n_pop;
        r_ovf  <= n_ovf;
        if (out_load) begin
            r_o_steps     <= r_pop;
            r_o_ovf       <= r_ovf;
            r_o_alpha     <= r_q;
            r_o_ovf_total <= n_ovf_cnt;
            r_o_total     <= n_popped;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.steps_now      = r_o_steps;
    assign o_out.overflowed     = r_o_ovf;
    assign o_out.alpha_q16      = r_o_alpha;
    assign o_out.overflow_total = r_o_ovf_total;
    assign o_out.steps_total    = r_o_total;

`ifndef NO_ASSERTIONS
    // fraction division keeps the partial remainder below one step
    a_alpha_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ALPHA) |-> (r_rem < PW'(step_eff)))
        else $error("fraction remainder not below step length");

    // a tick starts the first capped division on the next cycle
    a_tick_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in.cmd == fsts_pkg::CMD_TICK) |=> (r_state == ST_DIV1))
        else $error("tick did not start division");

    // popping never adds credit
    a_credit_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_POP) |=> (r_credit <= $past(r_credit)))
        else $error("credit grew while popping");
`endif

endmodule

### rtl/fsts_sub.sv
module fsts_sub #(
    parameter int W = fsts_pkg::TIME_POOL_BITS_DEF
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output logic [W-1:0] o_diff,
    output logic         o_ge
);

    logic [W:0] wide;

    assign wide   = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff = wide[W-1:0];
    assign o_ge   = ~wide[W];

endmodule

### dv/tb.sv
module tb;

    localparam int          POOL_BITS     = fsts_pkg::TIME_POOL_BITS_DEF;
    localparam logic [63:0] POOL_LIMIT    = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - POOL_BITS);
    localparam int          SETTLE_CYCLES = 60;
    localparam int          CYCLE_LIMIT   = 1000000;
    localparam int          HOLD_CYCLES   = 400;

    // indexes past the two registers, writes there must do nothing
    localparam fsts_pkg::t_cfg_idx CFG_SPARE_LO = 4'd2;
    localparam fsts_pkg::t_cfg_idx CFG_SPARE_HI = 4'd15;

    typedef struct packed {
        fsts_pkg::t_cmd cmd;
        logic [31:0]    frame;
        logic [31:0]    credit;
    } t_sched_item;

    typedef struct packed {
        logic [fsts_pkg::MAXS_W-1:0]    steps;
        logic                           overflowed;
        logic [fsts_pkg::ALPHA_W-1:0]   alpha;
        logic [fsts_pkg::OVF_CNT_W-1:0] ovf_total;
        logic [fsts_pkg::TOTAL_W-1:0]   total;
    } t_tick_report;

    logic i_clk;
    logic i_rst_n;

    fsts_cfg_if cfg_ch ();
    fsts_in_if  in_ch ();
    fsts_out_if out_ch ();

    fixed_step_tick_scheduler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_sched_item  pending_items[$];
    t_tick_report reports_due[$];

    // scheduler state as the block should hold it
    logic [31:0] step_cfg;
    logic [7:0]  max_cfg;
    logic [63:0] pool_units;
    logic [31:0] credit_steps;
    logic        paused;
    logic [31:0] ovf_ticks;
    logic [63:0] steps_sum;

    int items_queued;
    int items_taken;
    int ticks_taken;
    int reports_checked;
    int err_count;
    int cycle_count;

    int burst_left;
    int gap_left;
    int stall_mode;
    int stall_left;
    int pattern_phase;
    int hold_left;
    int holds_done;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [63:0] lesser(input logic [63:0] a, input logic [63:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic void apply_item(input fsts_pkg::t_cmd cmd, input logic [31:0] ft,
                                       input logic [31:0] ca);
        logic [63:0]  step;
        logic [63:0]  cap;
        logic [63:0]  add;
        logic [63:0]  sum;
        logic [63:0]  pop;
        logic [63:0]  credit_take;
        logic [63:0]  drop;
        logic [63:0]  alpha;
        t_tick_report rep;
        step = (step_cfg == 32'd0) ? 64'd1 : {32'd0, step_cfg};
        cap  = {56'd0, max_cfg};
        case (cmd)
            fsts_pkg::CMD_CREDIT: begin
                if (ca != 32'd0 && !ca[31]) begin
                    sum = {32'd0, credit_steps} + {32'd0, ca};
                    credit_steps = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
                end
            end
            fsts_pkg::CMD_PAUSE:  paused = 1'b1;
            fsts_pkg::CMD_RESUME: paused = 1'b0;
            fsts_pkg::CMD_TICK: begin
                if (!paused) begin
                    add = ft[31] ? 64'd0 : {32'd0, ft};
                    pool_units = (pool_units > POOL_LIMIT - add) ? POOL_LIMIT
                                                                 : pool_units + add;
                end
                // credit goes first, time pool makes up the rest
                pop = lesser(lesser(pool_units / step, cap) + {32'd0, credit_steps}, cap);
                credit_take = lesser({32'd0, credit_steps}, pop);
                credit_steps = credit_steps - credit_take[31:0];
                pool_units = pool_units - (pop - credit_take) * step;
                drop = lesser(pool_units / step, cap);
                rep.overflowed = 1'b0;
                if (drop != 64'd0) begin
                    pool_units = pool_units - drop * step;
                    if (ovf_ticks != 32'hFFFF_FFFF)
                        ovf_ticks = ovf_ticks + 32'd1;
                    rep.overflowed = 1'b1;
                end
                steps_sum = steps_sum + pop;
                if (paused)
                    alpha = 64'd0;
                else if (pool_units >= step)
                    alpha = 64'd65535;
                else begin
                    alpha = (pool_units << 16) / step;
                    if (alpha > 64'd65535)
                        alpha = 64'd65535;
                end
                rep.steps     = pop[7:0];
                rep.alpha     = alpha[15:0];
                rep.ovf_total = ovf_ticks;
                rep.total     = steps_sum;
                reports_due.push_back(rep);
            end
            default: ;
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        err_count++;
        $display("tb: %s mismatch on result %0d: got %0h, want %0h",
                 what, reports_checked, got, want);
    endtask

    function automatic logic [31:0] pick_frame(input logic [31:0] step_w,
                                               input logic [7:0] cap_w, input bit wide);
        logic [63:0] step;
        logic [63:0] span;
        int unsigned r;
        step = (step_w == 32'd0) ? 64'd1 : {32'd0, step_w};
        span = step * ((cap_w == 8'd0) ? 64'd1 : {56'd0, cap_w}) * 3 / 2 + step;
        if (span > 64'h7FFF_FFFF)
            span = 64'h7FFF_FFFF;
        r = $urandom_range(0, 9);
        if (r == 0)
            return $urandom | 32'h8000_0000;
        if (r == 1)
            return 32'd0;
        if (wide && r < 6)
            return $urandom;
        return $urandom_range(0, span[31:0]);
    endfunction

    function automatic logic [31:0] pick_credit(input bit wide);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 32'd0;
        if (r < 3)
            return $urandom | 32'h8000_0000;
        if (wide && r < 6)
            return $urandom;
        return $urandom_range(1, 6);
    endfunction

    task automatic push_item(input fsts_pkg::t_cmd cmd, input logic [31:0] ft,
                             input logic [31:0] ca);
        pending_items.push_back('{cmd: cmd, frame: ft, credit: ca});
        items_queued++;
    endtask

    task automatic queue_random(input int count, input logic [31:0] step_w,
                                input logic [7:0] cap_w, input bit wide);
        fsts_pkg::t_cmd c;
        int unsigned    w;
        for (int k = 0; k < count; k++) begin
            w = $urandom_range(0, 19);
            if (w < 12)
                c = fsts_pkg::CMD_TICK;
            else if (w < 16)
                c = fsts_pkg::CMD_CREDIT;
            else if (w < 17)
                c = fsts_pkg::CMD_PAUSE;
            else
                c = fsts_pkg::CMD_RESUME;
            push_item(c, (c == fsts_pkg::CMD_TICK) ? pick_frame(step_w, cap_w, wide) : $urandom,
                      (c == fsts_pkg::CMD_CREDIT) ? pick_credit(wide) : $urandom);
        end
    endtask

    task automatic write_reg(input fsts_pkg::t_cfg_idx idx, input logic [31:0] value);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
        cfg_ch.valid <= 1'b0;
    endtask

    // credit and pause items give no result, so allow for a tick still in flight
    task automatic drain_block();
        while (items_taken != items_queued || reports_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] rnd_step;
        logic [7:0]  rnd_cap;
        i_rst_n              = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.cmd            = fsts_pkg::CMD_TICK;
        in_ch.frame_time     = '0;
        in_ch.credit_amount  = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = fsts_pkg::CFG_STEP_UNITS;
        cfg_ch.data          = '0;
        out_ch.ready         = 1'b0;
        items_queued         = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // register values straight out of reset
        push_item(fsts_pkg::CMD_TICK, 32'd0, $urandom);
        push_item(fsts_pkg::CMD_TICK, 32'd16667, $urandom);
        push_item(fsts_pkg::CMD_TICK, 32'hFFFF_FFFF, $urandom);
        push_item(fsts_pkg::CMD_TICK, 32'h8000_0000, $urandom);
        push_item(fsts_pkg::CMD_TICK, 32'd183342, $urandom);
        push_item(fsts_pkg::CMD_CREDIT, $urandom, 32'd0);
        push_item(fsts_pkg::CMD_CREDIT, $urandom, 32'hFFFF_FFFF);
        push_item(fsts_pkg::CMD_CREDIT, $urandom, 32'h8000_0000);
        push_item(fsts_pkg::CMD_CREDIT, $urandom, 32'd3);
        push_item(fsts_pkg::CMD_TICK, 32'd0, $urandom);
        push_item(fsts_pkg::CMD_PAUSE, $urandom, $urandom);
        push_item(fsts_pkg::CMD_TICK, 32'd100000, $urandom);
        push_item(fsts_pkg::CMD_CREDIT, $urandom, 32'd7);
        push_item(fsts_pkg::CMD_TICK, 32'd0, $urandom);
        push_item(fsts_pkg::CMD_RESUME, $urandom, $urandom);
        push_item(fsts_pkg::CMD_TICK, 32'd20000, $urandom);
        queue_random(230, fsts_pkg::STEP_UNITS_RESET, fsts_pkg::MAX_STEPS_RESET, 1'b0);
        drain_block();

        // zero step length counts as one
        write_reg(fsts_pkg::CFG_STEP_UNITS, 32'd0);
        write_reg(fsts_pkg::CFG_MAX_STEPS, 32'd255);
        queue_random(140, 32'd0, 8'd255, 1'b0);
        drain_block();

        // zero step limit, nothing popped or dropped
        write_reg(fsts_pkg::CFG_STEP_UNITS, 32'd1000);
        write_reg(fsts_pkg::CFG_MAX_STEPS, 32'd0);
        push_item(fsts_pkg::CMD_TICK, 32'd5000, $urandom);
        queue_random(20, 32'd1000, 8'd0, 1'b0);
        drain_block();

        write_reg(fsts_pkg::CFG_STEP_UNITS, 32'd997);
        write_reg(fsts_pkg::CFG_MAX_STEPS, 32'd255);
        write_reg(CFG_SPARE_LO, 32'd0);
        write_reg(CFG_SPARE_HI, 32'd3);
        queue_random(280, 32'd997, 8'd255, 1'b0);
        drain_block();

        write_reg(fsts_pkg::CFG_STEP_UNITS, 32'd250);
        write_reg(fsts_pkg::CFG_MAX_STEPS, 32'd1);
        queue_random(140, 32'd250, 8'd1, 1'b0);
        drain_block();

        rnd_step = $urandom_range(50, 100000);
        rnd_cap  = $urandom_range(1, 32);
        write_reg(fsts_pkg::CFG_STEP_UNITS, rnd_step);
        write_reg(fsts_pkg::CFG_MAX_STEPS, {24'd0, rnd_cap});
        queue_random(280, rnd_step, rnd_cap, 1'b0);
        drain_block();

        // longest step, full frame range
        write_reg(fsts_pkg::CFG_STEP_UNITS, 32'hFFFF_FFFF);
        repeat (3) push_item(fsts_pkg::CMD_TICK, 32'h7FFF_FFFF, $urandom);
        queue_random(140, 32'hFFFF_FFFF, 8'd255, 1'b1);
        drain_block();

        // credit pool driven into saturation
        write_reg(fsts_pkg::CFG_STEP_UNITS, 32'h0010_0000);
        push_item(fsts_pkg::CMD_CREDIT, $urandom, 32'h7FFF_FFFF);
        push_item(fsts_pkg::CMD_CREDIT, $urandom, 32'h7FFF_FFFF);
        push_item(fsts_pkg::CMD_CREDIT, $urandom, 32'd1);
        push_item(fsts_pkg::CMD_TICK, 32'h7FFF_FFFF, $urandom);
        queue_random(200, 32'h0010_0000, 8'd255, 1'b1);
        drain_block();

        if (err_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    // item driver: bursts of random length, random gaps between them
    always @(posedge i_clk) begin : drive_items
        t_sched_item nxt;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            burst_left  <= 0;
            gap_left    <= 0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (gap_left != 0 || pending_items.size() == 0) begin
                in_ch.valid <= 1'b0;
                if (gap_left != 0)
                    gap_left <= gap_left - 1;
            end else begin
                nxt = pending_items.pop_front();
                in_ch.valid         <= 1'b1;
                in_ch.cmd           <= nxt.cmd;
                in_ch.frame_time    <= nxt.frame;
                in_ch.credit_amount <= nxt.credit;
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 16);
                    gap_left   <= ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 50);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // long receiver hold-off so the block backs up and stalls its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left  <= 0;
            holds_done <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if ((holds_done == 0 && ticks_taken >= 150) ||
                     (holds_done == 1 && ticks_taken >= 700)) begin
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready  <= 1'b0;
            stall_mode    <= 0;
            stall_left    <= 0;
            pattern_phase <= 0;
        end else begin
            pattern_phase <= pattern_phase + 1;
            if (stall_left == 0) begin
                stall_mode <= $urandom_range(0, 3);
                stall_left <= $urandom_range(10, 200);
            end else begin
                stall_left <= stall_left - 1;
            end
            if (hold_left != 0)
                out_ch.ready <= 1'b0;
            else
                case (stall_mode)
                    0:       out_ch.ready <= 1'b1;
                    1:       out_ch.ready <= $urandom_range(0, 1);
                    2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: out_ch.ready <= (pattern_phase % 7) < 3;
                endcase
        end
    end

    always @(posedge i_clk) begin : check_ports
        t_tick_report seen;
        t_tick_report want;
        if (!i_rst_n) begin
            step_cfg        = fsts_pkg::STEP_UNITS_RESET;
            max_cfg         = fsts_pkg::MAX_STEPS_RESET;
            pool_units      = '0;
            credit_steps    = '0;
            paused          = 1'b0;
            ovf_ticks       = '0;
            steps_sum       = '0;
            items_taken     = 0;
            ticks_taken     = 0;
            reports_checked = 0;
            err_count       = 0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready)
                case (cfg_ch.index)
                    fsts_pkg::CFG_STEP_UNITS: step_cfg = cfg_ch.data;
                    fsts_pkg::CFG_MAX_STEPS:  max_cfg  = cfg_ch.data[7:0];
                    default: ;
                endcase
            if (out_ch.valid && out_ch.ready) begin
                seen = '{steps: out_ch.steps_now, overflowed: out_ch.overflowed,
                         alpha: out_ch.alpha_q16, ovf_total: out_ch.overflow_total,
                         total: out_ch.steps_total};
                if (reports_due.size() == 0) begin
                    flag_mismatch("unexpected result", seen.total, 64'd0);
                end else begin
                    want = reports_due.pop_front();
                    if (seen.steps != want.steps)
                        flag_mismatch("steps_now", seen.steps, want.steps);
                    if (seen.overflowed != want.overflowed)
                        flag_mismatch("overflowed", seen.overflowed, want.overflowed);
                    if (seen.alpha != want.alpha)
                        flag_mismatch("alpha_q16", seen.alpha, want.alpha);
                    if (seen.ovf_total != want.ovf_total)
                        flag_mismatch("overflow_total", seen.ovf_total, want.ovf_total);
                    if (seen.total != want.total)
                        flag_mismatch("steps_total", seen.total, want.total);
                end
                reports_checked++;
            end
            if (in_ch.valid && in_ch.ready) begin
                apply_item(in_ch.cmd, in_ch.frame_time, in_ch.credit_amount);
                items_taken++;
                if (in_ch.cmd == fsts_pkg::CMD_TICK)
                    ticks_taken++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            cycle_count <= 0;
        else
            cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

endmodule
